[rtl/core/spwm_pkg.sv]
// Shared widths, register indexes and reset values for the servo PWM generator.
// Used by servo_pwm_with_slew_limit; depends on nothing else.
package spwm_pkg;

    localparam int COUNT_BITS = 20;
    localparam int POS_BITS   = 16;
    localparam int STEP_BITS  = POS_BITS + 1;
    localparam int CFG_BITS   = (COUNT_BITS > STEP_BITS) ? COUNT_BITS : STEP_BITS;
    localparam int IDX_BITS   = 2;

    typedef logic [COUNT_BITS-1:0]    count_t;
    typedef logic signed [POS_BITS-1:0] pos_t;
    typedef logic [STEP_BITS-1:0]     step_t;
    typedef logic [CFG_BITS-1:0]      cfg_data_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_PERIOD    = 2'd0,
        REG_MIN_PULSE = 2'd1,
        REG_MAX_PULSE = 2'd2,
        REG_SLEW_STEP = 2'd3
    } cfg_index_t;

    localparam count_t PERIOD_RESET    = count_t'(20000);
    localparam count_t MIN_PULSE_RESET = count_t'(1000);
    localparam count_t MAX_PULSE_RESET = count_t'(2000);
    localparam step_t  SLEW_STEP_RESET = step_t'(655);

endpackage

[rtl/core/servo_pwm_with_slew_limit.sv]
// Servo PWM generator with slew-rate limited position, one module.
// Depends on spwm_pkg for widths, register indexes and reset values.
//
// Usage:
// The input channel (in_valid, in_stall, target_pos) carries one request per
// PWM timebase tick, holding the commanded position in signed Q1.15. The
// output channel (out_valid, out_stall, pin_level, period_start, current_pos)
// returns exactly one request per accepted tick, in order.
// The counters and position update at the accepting edge and the result is
// registered, so it appears in the cycle after acceptance. One tick is
// accepted every cycle unless the output stalls; the limit is the single
// output register, which also accepts a new tick while its content is taken.
// When the receiver stalls with a result held, in_stall rises and no new tick
// is taken until the result is accepted. The pulse width multiply, the tick
// compare and the slew step are combinational. Reset clears the tick counter,
// the pulse width and the position (centre), loads the default configuration
// and empties the output register. The user must write configuration through
// cfg_we, cfg_index and cfg_data while idle; the block does not enforce it.
module servo_pwm_with_slew_limit
    import spwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [POS_BITS-1:0] target_pos,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  pin_level,
    output logic                  period_start,
    output logic signed [POS_BITS-1:0] current_pos
);

    localparam int WIDE_POS = POS_BITS + 2;

    count_t period_reg;
    count_t min_pulse_reg;
    count_t max_pulse_reg;
    step_t  slew_step_reg;

    count_t tick_count_reg;
    count_t tick_count_next;
    count_t pulse_width_reg;
    count_t pulse_width_next;
    pos_t   position_reg;
    pos_t   position_next;

    logic   out_valid_reg;
    logic   pin_level_reg;
    logic   pin_level_next;
    logic   period_start_reg;
    pos_t   current_pos_reg;

    logic   accept;
    logic   start;
    logic   period_end;
    count_t period_eff;
    count_t diff;
    logic [POS_BITS-1:0] offset;
    logic [COUNT_BITS+POS_BITS-1:0] product;
    count_t width_calc;
    logic [COUNT_BITS:0] tick_plus_one;

    logic signed [WIDE_POS-1:0] cur_wide;
    logic signed [WIDE_POS-1:0] tgt_wide;
    logic signed [WIDE_POS-1:0] step_wide;
    logic signed [WIDE_POS-1:0] down_wide;
    logic signed [WIDE_POS-1:0] up_wide;

    assign accept   = in_valid && !in_stall;
    assign in_stall = out_valid_reg && out_stall;

    always_comb
    begin
        start      = (tick_count_reg == '0);
        period_eff = (period_reg == '0) ? count_t'(1) : period_reg;
        tick_plus_one = {1'b0, tick_count_reg} + (COUNT_BITS+1)'(1);
        period_end = (tick_plus_one >= {1'b0, period_eff});

        diff    = max_pulse_reg - min_pulse_reg;
        offset  = {~position_reg[POS_BITS-1], position_reg[POS_BITS-2:0]};
        product = {{POS_BITS{1'b0}}, diff} * {{COUNT_BITS{1'b0}}, offset};
        if (max_pulse_reg < min_pulse_reg)
        begin
            width_calc = min_pulse_reg;
        end
        else
        begin
            width_calc = min_pulse_reg + product[COUNT_BITS+POS_BITS-1:POS_BITS];
        end

        pulse_width_next = start ? width_calc : pulse_width_reg;
        pin_level_next   = (tick_count_reg < pulse_width_next);

        cur_wide  = WIDE_POS'(position_reg);
        tgt_wide  = WIDE_POS'(target_pos);
        step_wide = signed'({1'b0, slew_step_reg});
        down_wide = cur_wide - step_wide;
        up_wide   = cur_wide + step_wide;

        position_next   = position_reg;
        tick_count_next = tick_plus_one[COUNT_BITS-1:0];
        if (period_end)
        begin
            tick_count_next = '0;
            priority if (tgt_wide < cur_wide)
            begin
                position_next = (down_wide < tgt_wide) ? target_pos
                                                       : pos_t'(down_wide);
            end
            else if (tgt_wide > cur_wide)
            begin
                position_next = (up_wide > tgt_wide) ? target_pos
                                                     : pos_t'(up_wide);
            end
            else
            begin
                position_next = position_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RESET;
            min_pulse_reg <= MIN_PULSE_RESET;
            max_pulse_reg <= MAX_PULSE_RESET;
            slew_step_reg <= SLEW_STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_PERIOD:    period_reg    <= cfg_data[COUNT_BITS-1:0];
                REG_MIN_PULSE: min_pulse_reg <= cfg_data[COUNT_BITS-1:0];
                REG_MAX_PULSE: max_pulse_reg <= cfg_data[COUNT_BITS-1:0];
                REG_SLEW_STEP: slew_step_reg <= cfg_data[STEP_BITS-1:0];
                default:       period_reg    <= period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            pulse_width_reg <= '0;
            position_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                tick_count_reg  <= tick_count_next;
                pulse_width_reg <= pulse_width_next;
                position_reg    <= position_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pin_level_reg    <= pin_level_next;
            period_start_reg <= start;
            current_pos_reg  <= position_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pin_level    = pin_level_reg;
    assign period_start = period_start_reg;
    assign current_pos  = current_pos_reg;

`ifndef SYNTHESIS
    a_accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("Accepted tick did not produce a result.");

    a_start_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (tick_count_reg == '0) |=> period_start_reg)
        else $error("Period start not flagged on a zero tick count.");

    a_position_moves_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && period_end) |=> $stable(position_reg))
        else $error("Position changed away from a period end.");

    a_width_latched_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && start |=> pulse_width_reg == $past(width_calc))
        else $error("Pulse width not latched at period start.");

    a_width_held_mid_period: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && start) |=> $stable(pulse_width_reg))
        else $error("Pulse width changed within a period.");
`endif

endmodule
